// ===== design/dswt_pkg.sv =====
// Shared types and constants for the debounced store write table.
package dswt_pkg;

  localparam int SLOT_COUNT = 4;
  localparam int KEY_BITS = 8;
  localparam int KEY_W = 8;
  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(SLOT_COUNT - 1);
  localparam logic [KEY_W-1:0] KEY_MASK =
    (KEY_BITS >= KEY_W) ? {KEY_W{1'b1}} : KEY_W'((1 << KEY_BITS) - 1);

  typedef enum logic [1:0] {
    CMD_IMM  = 2'd0,
    CMD_DEB  = 2'd1,
    CMD_POLL = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE,
    ST_POLL_EMIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [KEY_W-1:0] key_id;
    logic [31:0]      value;
    logic [31:0]      min_interval;
    logic             force_req;
    logic [31:0]      now_ms;
  } in_t;

  typedef struct packed {
    logic [KEY_W-1:0] store_key;
    logic [31:0]      store_value;
    logic             last;
  } out_t;

endpackage

// ===== design/dswt_due_unit.sv =====
// Shared elapsed-time compare unit: wrapping time since last write against a threshold.
module dswt_due_unit (
  input  logic [31:0] now_ms,
  input  logic [31:0] last_ms,
  input  logic [31:0] thr_ms,
  output logic        due
);

  logic [31:0] elapsed;

  assign elapsed = now_ms - last_ms;
  assign due = (elapsed >= thr_ms);

endmodule

// ===== design/debounced_store_write_table.sv =====
// Top level of the debounced store write table with its slot table and sequencer.
// A write item scans all slots in ST_SCAN, then resolves in ST_RESOLVE before any result.
// A poll scans all slots in ST_SCAN, then walks slots in ST_POLL_EMIT to each due entry.
// The slot scan runs one slot per cycle through the shared elapsed-time compare unit.
// The input is not ready again until the final result of an item has been transferred.
// Reset is synchronous, active low, and closes the store and marks every slot unused.
module debounced_store_write_table (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dswt_pkg::in_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output dswt_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_data
);

  dswt_pkg::state_t state_r, state_nxt;
  dswt_pkg::in_t    req_r, req_nxt;
  dswt_pkg::out_t   out_data_r, out_data_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             store_ready_r;

  logic [dswt_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic [dswt_pkg::IDX_W-1:0] hit_r, hit_nxt;
  logic [dswt_pkg::IDX_W-1:0] free_r, free_nxt;
  logic [dswt_pkg::IDX_W-1:0] rd_idx;
  logic                       found_r, found_nxt;
  logic                       free_found_r, free_found_nxt;
  logic [dswt_pkg::SLOT_COUNT-1:0] mask_r, mask_nxt;

  logic [dswt_pkg::SLOT_COUNT-1:0] used_r, used_nxt;
  logic [dswt_pkg::SLOT_COUNT-1:0] pending_r, pending_nxt;
  logic [dswt_pkg::KEY_W-1:0] key_r [dswt_pkg::SLOT_COUNT];
  logic [dswt_pkg::KEY_W-1:0] key_nxt [dswt_pkg::SLOT_COUNT];
  logic [31:0] value_r [dswt_pkg::SLOT_COUNT];
  logic [31:0] value_nxt [dswt_pkg::SLOT_COUNT];
  logic [31:0] last_r [dswt_pkg::SLOT_COUNT];
  logic [31:0] last_nxt [dswt_pkg::SLOT_COUNT];
  logic [31:0] interval_r [dswt_pkg::SLOT_COUNT];
  logic [31:0] interval_nxt [dswt_pkg::SLOT_COUNT];

  logic        in_xfer;
  logic        cmd_known;
  logic        emit;
  logic        due;
  logic [31:0] unit_last;
  logic [31:0] unit_thr;

  assign in_ready  = (state_r == dswt_pkg::ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;
  assign cmd_known = in_data.cmd inside {dswt_pkg::CMD_IMM, dswt_pkg::CMD_DEB,
                                         dswt_pkg::CMD_POLL};

  assign rd_idx    = (state_r == dswt_pkg::ST_RESOLVE) ? hit_r : idx_r;
  assign unit_last = (state_r == dswt_pkg::ST_RESOLVE && !found_r) ? 32'd0 : last_r[rd_idx];
  assign unit_thr  = (state_r == dswt_pkg::ST_RESOLVE) ? req_r.min_interval
                                                       : interval_r[rd_idx];

  dswt_due_unit u_due (
    .now_ms  (req_r.now_ms),
    .last_ms (unit_last),
    .thr_ms  (unit_thr),
    .due     (due)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dswt_pkg::ST_IDLE: begin
        if (in_xfer && store_ready_r && cmd_known) begin
          state_nxt = dswt_pkg::ST_SCAN;
        end
      end
      dswt_pkg::ST_SCAN: begin
        if (idx_r == dswt_pkg::IDX_MAX) begin
          if (req_r.cmd != dswt_pkg::CMD_POLL) begin
            state_nxt = dswt_pkg::ST_RESOLVE;
          end else if (mask_nxt == '0) begin
            state_nxt = dswt_pkg::ST_IDLE;
          end else begin
            state_nxt = dswt_pkg::ST_POLL_EMIT;
          end
        end
      end
      dswt_pkg::ST_RESOLVE: begin
        state_nxt = emit ? dswt_pkg::ST_OUT : dswt_pkg::ST_IDLE;
      end
      dswt_pkg::ST_POLL_EMIT: begin
        if (mask_r[idx_r]) begin
          state_nxt = dswt_pkg::ST_OUT;
        end
      end
      dswt_pkg::ST_OUT: begin
        if (out_ready) begin
          state_nxt = out_data_r.last ? dswt_pkg::ST_IDLE : dswt_pkg::ST_POLL_EMIT;
        end
      end
      default: begin
        state_nxt = dswt_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    logic                       slot_ok;
    logic                       imm;
    logic [dswt_pkg::IDX_W-1:0] s;
    logic [dswt_pkg::SLOT_COUNT-1:0] rest;

    req_nxt        = req_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r;
    idx_nxt        = idx_r;
    hit_nxt        = hit_r;
    free_nxt       = free_r;
    found_nxt      = found_r;
    free_found_nxt = free_found_r;
    mask_nxt       = mask_r;
    used_nxt       = used_r;
    pending_nxt    = pending_r;
    key_nxt        = key_r;
    value_nxt      = value_r;
    last_nxt       = last_r;
    interval_nxt   = interval_r;
    emit           = 1'b0;
    slot_ok        = found_r || free_found_r;
    s              = found_r ? hit_r : free_r;
    imm            = 1'b0;
    rest           = mask_r & ~(dswt_pkg::SLOT_COUNT'(1) << idx_r);

    case (state_r)
      dswt_pkg::ST_IDLE: begin
        if (in_xfer) begin
          req_nxt        = in_data;
          req_nxt.key_id = in_data.key_id & dswt_pkg::KEY_MASK;
          idx_nxt        = '0;
          found_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          mask_nxt       = '0;
        end
      end
      dswt_pkg::ST_SCAN: begin
        if (req_r.cmd == dswt_pkg::CMD_POLL) begin
          mask_nxt[rd_idx] = used_r[rd_idx] && pending_r[rd_idx] && due;
        end else begin
          if (used_r[rd_idx] && key_r[rd_idx] == req_r.key_id && !found_r) begin
            found_nxt = 1'b1;
            hit_nxt   = rd_idx;
          end
          if (!used_r[rd_idx] && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_nxt       = rd_idx;
          end
        end
        idx_nxt = (idx_r == dswt_pkg::IDX_MAX) ? '0 : idx_r + 1'b1;
      end
      dswt_pkg::ST_RESOLVE: begin
        imm = (req_r.cmd != dswt_pkg::CMD_DEB) || req_r.force_req ||
              (req_r.min_interval == 32'd0) || !slot_ok;
        if (slot_ok && !found_r) begin
          used_nxt[s]     = 1'b1;
          key_nxt[s]      = req_r.key_id;
          pending_nxt[s]  = 1'b0;
          last_nxt[s]     = 32'd0;
          interval_nxt[s] = 32'd0;
        end
        if (imm) begin
          emit = 1'b1;
        end else begin
          interval_nxt[s] = req_r.min_interval;
          value_nxt[s]    = req_r.value;
          pending_nxt[s]  = 1'b1;
          emit            = due;
        end
        if (emit) begin
          if (slot_ok) begin
            pending_nxt[s] = 1'b0;
            last_nxt[s]    = req_r.now_ms;
          end
          out_data_nxt.store_key   = req_r.key_id;
          out_data_nxt.store_value = req_r.value;
          out_data_nxt.last        = 1'b1;
          out_valid_nxt            = 1'b1;
        end
      end
      dswt_pkg::ST_POLL_EMIT: begin
        if (mask_r[rd_idx]) begin
          out_data_nxt.store_key   = key_r[rd_idx];
          out_data_nxt.store_value = value_r[rd_idx];
          out_data_nxt.last        = (rest == '0);
          out_valid_nxt            = 1'b1;
          mask_nxt                 = rest;
          pending_nxt[rd_idx]      = 1'b0;
          last_nxt[rd_idx]         = req_r.now_ms;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      dswt_pkg::ST_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (!out_data_r.last) begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= dswt_pkg::ST_IDLE;
      out_valid_r   <= 1'b0;
      store_ready_r <= 1'b0;
      used_r        <= '0;
      pending_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      used_r      <= used_nxt;
      pending_r   <= pending_nxt;
      if (cfg_valid && cfg_ready) begin
        store_ready_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    out_data_r   <= out_data_nxt;
    idx_r        <= idx_nxt;
    hit_r        <= hit_nxt;
    free_r       <= free_nxt;
    found_r      <= found_nxt;
    free_found_r <= free_found_nxt;
    mask_r       <= mask_nxt;
    key_r        <= key_nxt;
    value_r      <= value_nxt;
    last_r       <= last_nxt;
    interval_r   <= interval_nxt;
  end

endmodule

// ===== design/dswt_checker.sv =====
// Port-level assertions for the debounced store write table and their bind.
module dswt_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input dswt_pkg::out_t out_data
);

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("Block is not idle after reset.");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("Input is ready while a result is pending.");

  a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last |=> !in_ready)
    else $error("Input became ready before the final result of a poll.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Result changed before its transfer.");

endmodule

bind debounced_store_write_table dswt_checker u_dswt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== verif/tb.sv =====
// Testbench for the debounced store write table with a predicting scoreboard.
`timescale 1ns / 100ps

module tb;
  import dswt_pkg::*;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam int SETTLE_CYCLES = 4 * SLOT_COUNT + 8;
  localparam int DRAIN_LIMIT = 4000;

  class store_write_checker;
    out_t expected_writes[$];
    int mismatches;
    int writes_checked;
    int items_noted;
    int most_writes;
    bit is_open;
    bit slot_used [SLOT_COUNT];
    bit [KEY_W-1:0] slot_key [SLOT_COUNT];
    bit slot_pending [SLOT_COUNT];
    bit [31:0] slot_value [SLOT_COUNT];
    bit [31:0] slot_last_write [SLOT_COUNT];
    bit [31:0] slot_interval [SLOT_COUNT];

    task report(string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      mismatches++;
    endtask

    function int find_or_claim_slot(bit [KEY_W-1:0] key);
      for (int i = 0; i < SLOT_COUNT; i++)
        if (slot_used[i] && slot_key[i] == key) return i;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (!slot_used[i]) begin
          slot_used[i] = 1'b1;
          slot_key[i] = key;
          slot_pending[i] = 1'b0;
          slot_last_write[i] = '0;
          slot_interval[i] = '0;
          return i;
        end
      end
      return -1;
    endfunction

    function void record_write(bit [KEY_W-1:0] key, bit [31:0] val, bit [31:0] now);
      out_t w;
      int s;
      w.store_key = key;
      w.store_value = val;
      w.last = 1'b0;
      expected_writes.push_back(w);
      s = find_or_claim_slot(key);
      if (s >= 0) begin
        slot_pending[s] = 1'b0;
        slot_last_write[s] = now;
      end
    endfunction

    function void note_input(in_t item);
      bit [KEY_W-1:0] key;
      bit [31:0] elapsed;
      int s;
      int start;
      if (!is_open) return;
      items_noted++;
      start = expected_writes.size();
      key = item.key_id & KEY_MASK;
      case (item.cmd)
        CMD_IMM: record_write(key, item.value, item.now_ms);
        CMD_DEB: begin
          if (item.force_req || item.min_interval == 0) begin
            record_write(key, item.value, item.now_ms);
          end else begin
            s = find_or_claim_slot(key);
            if (s < 0) begin
              record_write(key, item.value, item.now_ms);
            end else begin
              slot_interval[s] = item.min_interval;
              slot_value[s] = item.value;
              slot_pending[s] = 1'b1;
              elapsed = item.now_ms - slot_last_write[s];
              if (elapsed >= slot_interval[s]) record_write(key, slot_value[s], item.now_ms);
            end
          end
        end
        CMD_POLL: begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            elapsed = item.now_ms - slot_last_write[i];
            if (slot_used[i] && slot_pending[i] && elapsed >= slot_interval[i])
              record_write(slot_key[i], slot_value[i], item.now_ms);
          end
        end
        default: ;
      endcase
      if (expected_writes.size() > start)
        expected_writes[expected_writes.size() - 1].last = 1'b1;
      if (expected_writes.size() - start > most_writes)
        most_writes = expected_writes.size() - start;
    endfunction

    task check_write(out_t got);
      out_t want;
      if (expected_writes.size() == 0) begin
        report($sformatf("store write key %0h value %0h with none expected",
                         got.store_key, got.store_value));
        return;
      end
      want = expected_writes.pop_front();
      writes_checked++;
      if (got.store_key !== want.store_key)
        report($sformatf("store_key %0h, expected %0h", got.store_key, want.store_key));
      if (got.store_value !== want.store_value)
        report($sformatf("store_value %0h, expected %0h", got.store_value, want.store_value));
      if (got.last !== want.last)
        report($sformatf("last %0b, expected %0b", got.last, want.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  store_write_checker sb = new;
  bit [31:0] ms_clock = 32'hFFFF_FF00;
  int closed_items;
  int stall_left;
  int ready_left;

  debounced_store_write_table uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  initial begin
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (ready_left > 0) begin
      out_ready <= 1'b1;
      ready_left--;
    end else begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) begin
        out_ready <= 1'b1;
        ready_left = $urandom_range(1, 30);
      end else if (r < 88) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(10, 30);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_write(out_data);
  end

  function automatic in_t write_item(logic [1:0] cmd, logic [KEY_W-1:0] key,
                                     logic [31:0] val, logic [31:0] ivl,
                                     logic force_req, logic [31:0] now);
    in_t it;
    it.cmd = cmd;
    it.key_id = key;
    it.value = val;
    it.min_interval = ivl;
    it.force_req = force_req;
    it.now_ms = now;
    return it;
  endfunction

  function automatic in_t random_item();
    in_t it;
    int r;
    int s;
    r = $urandom_range(0, 99);
    it.cmd = (r < 25) ? CMD_IMM : (r < 70) ? CMD_DEB : (r < 96) ? CMD_POLL : CMD_UNKNOWN;
    s = $urandom_range(0, SLOT_COUNT - 1);
    if ($urandom_range(0, 9) < 7 && sb.slot_used[s]) it.key_id = sb.slot_key[s];
    else it.key_id = KEY_W'($urandom_range(0, 255));
    it.value = $urandom();
    r = $urandom_range(0, 99);
    if (r < 10) it.min_interval = '0;
    else if (r < 80) it.min_interval = $urandom_range(1, 120);
    else if (r < 92) it.min_interval = $urandom_range(121, 5000);
    else it.min_interval = $urandom();
    it.force_req = ($urandom_range(0, 9) == 0);
    if ($urandom_range(0, 99) < 3) ms_clock = $urandom();
    else ms_clock = ms_clock + $urandom_range(0, 40);
    it.now_ms = ($urandom_range(0, 99) < 5) ? $urandom() : ms_clock;
    return it;
  endfunction

  task automatic send_item(input in_t it);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    if (!sb.is_open) closed_items++;
    sb.note_input(it);
  endtask

  task automatic pause_sender(input int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic sender_gap(input int idx);
    int r;
    if ((idx / 8) % 3 == 0) return;
    r = $urandom_range(0, 99);
    if (r < 45) return;
    if (r < 85) pause_sender($urandom_range(1, 3));
    else if (r < 96) pause_sender($urandom_range(4, 10));
    else pause_sender($urandom_range(20, 40));
  endtask

  task automatic drain_writes();
    pause_sender(1);
    while (sb.expected_writes.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    drain_writes();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_store_ready(input logic is_open);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= is_open;
    do @(posedge clk); while (!cfg_ready);
    sb.is_open = is_open;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_run(input int target);
    in_t it;
    int counted;
    int idx;
    counted = 0;
    idx = 0;
    while (counted < target) begin
      it = random_item();
      sender_gap(idx);
      send_item(it);
      if (it.cmd != CMD_UNKNOWN) counted++;
      idx++;
      if ($urandom_range(0, 19) == 0) drain_writes();
    end
  endtask

  task automatic closed_run(input int count);
    for (int i = 0; i < count; i++) begin
      sender_gap(i + 8);
      send_item(random_item());
    end
  endtask

  initial begin
    int waited;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_store_ready(1'b0);
    closed_run(6);
    settle();
    write_store_ready(1'b1);

    send_item(write_item(CMD_DEB, 8'h00, 32'h0, 32'd100, 1'b0, 32'd50));
    send_item(write_item(CMD_POLL, 8'h00, 32'h0, 32'd0, 1'b0, 32'd99));
    send_item(write_item(CMD_POLL, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd100));
    send_item(write_item(CMD_IMM, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
    send_item(write_item(CMD_DEB, 8'hFF, 32'h1234_5678, 32'd10, 1'b0, 32'd8));
    pause_sender(3);
    send_item(write_item(CMD_DEB, 8'hFF, 32'hA5A5_A5A5, 32'd10, 1'b0, 32'd9));
    send_item(write_item(CMD_DEB, 8'h55, 32'h5A5A_5A5A, 32'd1000, 1'b1, 32'd200));
    send_item(write_item(CMD_DEB, 8'hAA, 32'h0F0F_0F0F, 32'd0, 1'b0, 32'd300));
    send_item(write_item(CMD_DEB, 8'h01, 32'h0000_0001, 32'd500, 1'b0, 32'd400));
    send_item(write_item(CMD_IMM, 8'h02, 32'h8000_0000, 32'd0, 1'b0, 32'd401));
    send_item(write_item(CMD_DEB, 8'h00, 32'hDEAD_BEEF, 32'd1000, 1'b0, 32'd400));
    send_item(write_item(CMD_DEB, 8'h55, 32'hC001_D00D, 32'd2000, 1'b0, 32'd400));
    pause_sender(12);
    send_item(write_item(CMD_DEB, 8'hAA, 32'h7FFF_FFFF, 32'd5, 1'b0, 32'd302));
    send_item(write_item(CMD_DEB, 8'hFF, 32'hFEDC_BA98, 32'd50, 1'b0, 32'd20));
    send_item(write_item(CMD_POLL, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF));
    send_item(write_item(CMD_POLL, 8'h00, 32'h0, 32'd0, 1'b0, 32'd0));
    send_item(write_item(CMD_UNKNOWN, 8'h00, 32'h1111_1111, 32'd0, 1'b1, 32'd1));
    send_item(write_item(CMD_DEB, 8'h00, 32'h2468_ACE0, 32'hFFFF_FFFF, 1'b0, 32'd5));
    send_item(write_item(CMD_POLL, 8'h00, 32'h0, 32'd0, 1'b0, 32'd4));
    send_item(write_item(CMD_POLL, 8'h00, 32'h0, 32'd0, 1'b0, 32'hFFFF_FFFE));
    drain_writes();

    random_run(45);
    settle();
    write_store_ready(1'b0);
    closed_run(5);
    settle();
    write_store_ready(1'b1);
    random_run(45);

    pause_sender(1);
    waited = 0;
    while (sb.expected_writes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (sb.expected_writes.size() != 0) begin
      sb.report($sformatf("expected store write key %0h never came",
                          sb.expected_writes[0].store_key));
      void'(sb.expected_writes.pop_front());
    end

    $display("Run covered %0d items with the store open and %0d with it closed.",
             sb.items_noted, closed_items);
    $display("Checked %0d store writes, up to %0d from one item.",
             sb.writes_checked, sb.most_writes);
    if (sb.mismatches == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/dswt_pkg.sv
design/dswt_due_unit.sv
design/debounced_store_write_table.sv
design/dswt_checker.sv
verif/tb.sv
